[rtl/core/assert_macros.svh]
// Assertion macros shared by the cross dilation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every rising clock edge out of reset.
`define BCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define BCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bcd_pkg.sv]
// Shared types and constants for the cross dilation block.
`default_nettype none
package bcd_pkg;

  localparam int MAX_SIDE = 1024;
  localparam int MIN_SIDE = 3;
  localparam int CFG_W    = 11;
  localparam int COL_W    = $clog2(MAX_SIDE);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 2);
  localparam int ADDR_W   = 2;
  localparam int DATA_W   = 32;

  localparam logic [ADDR_W-1:0] REG_IMAGE_SIDE = ADDR_W'(0);
  localparam logic [CFG_W-1:0]  SIDE_RESET     = CFG_W'(12);

  // column triple: bit 0 top row, bit 1 middle row, bit 2 bottom row
  typedef logic [2:0] col_t;

  // line buffer entry: bit 0 upper line, bit 1 middle line
  typedef logic [1:0] line_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/core/bcd_line.sv]
// Paired line buffers (upper and middle rows) with registered read and write bypass.
`default_nettype none
module bcd_line (
  input  wire logic                    clk,
  input  wire logic                    rd_en,
  input  wire logic [bcd_pkg::COL_W-1:0] rd_addr,
  input  wire logic                    wr_en,
  input  wire logic [bcd_pkg::COL_W-1:0] wr_addr,
  input  wire bcd_pkg::line_t          wr_data,
  output bcd_pkg::line_t               rd_data
);

  bcd_pkg::line_t mem [bcd_pkg::MAX_SIDE];
  bcd_pkg::line_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/core/bcd_cell.sv]
// One window cell: holds a column triple and passes it to the next cell.
`default_nettype none
module bcd_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bcd_pkg::cell_ctl_t ctl,
  input  wire bcd_pkg::col_t      col_in,
  output bcd_pkg::col_t           col_out
);

  bcd_pkg::col_t col_r;
  bcd_pkg::col_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (ctl.clear) begin
      col_nxt = '0;
    end else if (ctl.shift) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule
`default_nettype wire

[rtl/core/binary_cross_dilation.sv]
// Top level of the streaming 3x3 cross dilation over a square binary image.
// Usage:
//   in_* channel: one pixel per beat in raster order; tuser marks a drain beat
//   whose pixel is taken as 0. After side*side pixels send side+1 drain beats.
//   out_* channel: dilated pixels in raster order, border pixels 0; tlast on the
//   last pixel of the frame. The first side+1 beats of a frame give no output.
//   cfg_* port: register 0 (address 0) is image_side, clamped to 3..1024.
//   A write restarts the frame; write only while the block is idle.
// Timing: one beat per cycle sustained while out_tready stays high. A result is
//   registered in the window stage (with the line buffer read), then in the
//   output register. The block lags the image by one row plus one pixel.
// Reset: counters and window cleared, image_side = 12. Line buffer contents
//   are not cleared; entries are written before any interior pixel uses them.
// Stall: when out_tready is low with a result held, the output register holds;
//   the window stage and then in_tready back up behind it, so no beat is lost.
`default_nettype none
module binary_cross_dilation (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [0] pixel_in
  input  wire logic [0:0]                    in_tuser,   // [0] pad
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,  // [0] pixel_out
  output logic                               out_tlast,  // frame_end
  // configuration
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [bcd_pkg::ADDR_W-1:0]    cfg_paddr,
  input  wire logic [bcd_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [bcd_pkg::DATA_W-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  `include "assert_macros.svh"

  // configuration
  logic [bcd_pkg::CFG_W-1:0]  side_r;
  logic                       cfg_wr;
  logic [31:0]                side_raw;
  logic [31:0]                side_clamp;
  logic [bcd_pkg::SIDE_W-1:0] n_side;
  logic [bcd_pkg::SIDE_W-1:0] n_plus1;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == bcd_pkg::REG_IMAGE_SIDE);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == bcd_pkg::REG_IMAGE_SIDE) begin
      cfg_prdata = bcd_pkg::DATA_W'(side_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= bcd_pkg::SIDE_RESET;
    end else if (cfg_wr) begin
      side_r <= cfg_pwdata[bcd_pkg::CFG_W-1:0];
    end
  end

  assign side_raw = 32'(side_r);

  always_comb begin
    if (side_raw < 32'(bcd_pkg::MIN_SIDE)) begin
      side_clamp = 32'(bcd_pkg::MIN_SIDE);
    end else if (side_raw > 32'(bcd_pkg::MAX_SIDE)) begin
      side_clamp = 32'(bcd_pkg::MAX_SIDE);
    end else begin
      side_clamp = side_raw;
    end
  end

  assign n_side  = side_clamp[bcd_pkg::SIDE_W-1:0];
  assign n_plus1 = n_side + bcd_pkg::SIDE_W'(1);

  // position counters, advanced on each accepted beat
  logic [bcd_pkg::COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [bcd_pkg::SIDE_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [bcd_pkg::SIDE_W-1:0] seen_r, seen_nxt;
  logic [bcd_pkg::SIDE_W-1:0] col_ext;
  logic                       in_fire;
  logic                       a_emit;
  logic                       a_last;
  logic                       a_restart;
  logic                       a_interior;
  logic                       a_pix;

  // window stage
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_pix_r;
  logic [bcd_pkg::COL_W-1:0] s1_col_r;
  logic                      s1_emit_r;
  logic                      s1_int_r;
  logic                      s1_last_r;
  logic                      s1_fire;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_pix_r;
  logic out_last_r;

  assign col_ext    = bcd_pkg::SIDE_W'(col_cnt_r);
  assign a_pix      = in_tdata[0] & ~in_tuser[0];
  assign a_emit     = seen_r >= n_plus1;
  assign a_last     = (col_cnt_r == '0) && (row_cnt_r == n_plus1);
  assign a_restart  = a_emit && a_last;
  assign a_interior = (col_ext >= bcd_pkg::SIDE_W'(2))
                      && (col_ext <= n_side - bcd_pkg::SIDE_W'(1))
                      && (row_cnt_r >= bcd_pkg::SIDE_W'(2))
                      && (row_cnt_r <= n_side - bcd_pkg::SIDE_W'(1));

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    seen_nxt    = seen_r;
    if (cfg_wr) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
      seen_nxt    = '0;
    end else if (in_fire) begin
      if (a_restart) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
        seen_nxt    = '0;
      end else begin
        if (seen_r < n_plus1) begin
          seen_nxt = seen_r + bcd_pkg::SIDE_W'(1);
        end
        if (col_ext + bcd_pkg::SIDE_W'(1) >= n_side) begin
          col_cnt_nxt = '0;
          if (row_cnt_r < n_plus1) begin
            row_cnt_nxt = row_cnt_r + bcd_pkg::SIDE_W'(1);
          end
        end else begin
          col_cnt_nxt = col_cnt_r + bcd_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      seen_r    <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      seen_r    <= seen_nxt;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= a_pix;
      s1_col_r  <= col_cnt_r;
      s1_emit_r <= a_emit;
      s1_int_r  <= a_interior;
      s1_last_r <= a_last;
    end
  end

  // line buffers
  bcd_pkg::line_t rd_line;
  bcd_pkg::line_t wr_line;

  assign wr_line = {s1_pix_r, rd_line[1]};

  bcd_line u_line (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_cnt_r),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (wr_line),
    .rd_data (rd_line)
  );

  // window cells
  bcd_pkg::col_t     cur_col;
  bcd_pkg::col_t     prev_col;
  bcd_pkg::col_t     older_col;
  bcd_pkg::cell_ctl_t cell_ctl;
  logic              pix_val;

  assign cur_col        = {s1_pix_r, rd_line[1], rd_line[0]};
  assign cell_ctl.clear = cfg_wr || (s1_fire && s1_emit_r && s1_last_r);
  assign cell_ctl.shift = s1_fire;

  bcd_cell u_cell_prev (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cell_ctl),
    .col_in  (cur_col),
    .col_out (prev_col)
  );

  bcd_cell u_cell_older (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cell_ctl),
    .col_in  (prev_col),
    .col_out (older_col)
  );

  assign pix_val = s1_int_r && (prev_col[0] || prev_col[1] || prev_col[2]
                                || older_col[1] || cur_col[1]);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_emit_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      out_pix_r  <= pix_val;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_pix_r};
  assign out_tlast  = out_last_r;

  `BCD_ASSERT(a_col_range, col_ext < n_side, "column count beyond image side")
  `BCD_ASSERT(a_row_range, row_cnt_r <= n_plus1, "row count beyond drain row")
  `BCD_ASSERT_NOW(a_last_border, out_valid_r && out_last_r, !out_pix_r,
    "frame end pixel not on border")
  `BCD_ASSERT_NEXT(a_restart_clr, in_fire && a_restart,
    (seen_r == '0) && (col_cnt_r == '0) && (row_cnt_r == '0), "frame restart missed")
  `BCD_ASSERT_NEXT(a_fill_quiet, in_fire && !a_emit && !cfg_wr,
    s1_valid_r && !s1_emit_r, "result flagged during line fill")

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for binary_cross_dilation: queued pixel driver, predictor, result monitor.
module tb;

  typedef struct packed {
    logic pad;
    logic pix;
  } pixel_beat_t;

  typedef struct packed {
    logic fend;
    logic pix;
  } dilated_px_t;

  localparam int LONG_HOLD  = 120;
  localparam int HOLD_AT_A  = 40;
  localparam int HOLD_AT_B  = 1500;
  localparam int PRINT_CAP  = 50;
  localparam int DRAIN_WAIT = 8;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [7:0]                 in_tdata;    // [0] pixel_in
  logic [0:0]                 in_tuser;    // [0] pad
  logic                       out_tvalid;
  logic                       out_tready;
  logic [7:0]                 out_tdata;   // [0] pixel_out
  logic                       out_tlast;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [bcd_pkg::ADDR_W-1:0] cfg_paddr;
  logic [bcd_pkg::DATA_W-1:0] cfg_pwdata;
  logic [bcd_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;

  pixel_beat_t pixel_fifo[$];
  dilated_px_t dilated_px_q[$];
  pixel_beat_t next_beat;
  dilated_px_t want_px;

  int mismatches   = 0;
  int results_seen = 0;
  int phase_items  = 0;
  int tx_gap       = 0;
  int rx_wait      = 0;
  int rx_draw;
  int cycle_cnt    = 0;
  int hold_left    = 0;
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;

  // predictor state
  logic [bcd_pkg::CFG_W-1:0] side_reg;
  logic                      line_two_up [bcd_pkg::MAX_SIDE];
  logic                      line_one_up [bcd_pkg::MAX_SIDE];
  logic [5:0]                taps;
  int                        col_pos;
  int                        row_pos;
  int                        beats_in_frame;

  binary_cross_dilation uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int side_eff();
    if (side_reg < bcd_pkg::MIN_SIDE) return bcd_pkg::MIN_SIDE;
    if (side_reg > bcd_pkg::MAX_SIDE) return bcd_pkg::MAX_SIDE;
    return int'(side_reg);
  endfunction

  task automatic restart_frame();
    taps           = '0;
    col_pos        = 0;
    row_pos        = 0;
    beats_in_frame = 0;
  endtask

  task automatic predict_dilated(input logic pix, input logic pad);
    int          n;
    int          c;
    int          r;
    logic        p;
    logic        top;
    logic        mid;
    logic [2:0]  cur;
    logic [2:0]  prv;
    logic [2:0]  old;
    logic        emit;
    logic        inner;
    logic        last;
    dilated_px_t e;
    n   = side_eff();
    c   = col_pos;
    r   = row_pos;
    p   = pad ? 1'b0 : pix;
    top = line_two_up[c];
    mid = line_one_up[c];
    line_two_up[c] = mid;
    line_one_up[c] = p;
    cur   = {p, mid, top};
    prv   = taps[2:0];
    old   = taps[5:3];
    emit  = beats_in_frame >= n + 1;
    inner = c >= 2 && c <= n - 1 && r >= 2 && r <= n - 1;
    last  = c == 0 && r == n + 1;
    if (emit) begin
      e.pix  = inner ? (|prv | old[1] | cur[1]) : 1'b0;
      e.fend = last;
      dilated_px_q.push_back(e);
    end
    if (emit && last) begin
      restart_frame();
    end else begin
      taps = {prv, cur};
      if (beats_in_frame < n + 1) beats_in_frame++;
      if (c + 1 >= n) begin
        col_pos = 0;
        if (row_pos < n + 1) row_pos++;
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  // input side: one beat per slot, random gap after each accepted beat when tx_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_dilated(in_tdata[0], in_tuser[0]);
      if (in_tvalid && !in_tready) begin
      end else if (tx_gap > 0) begin
        tx_gap    <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pixel_fifo.size() > 0) begin
        next_beat = pixel_fifo.pop_front();
        in_tdata  <= {7'b0, next_beat.pix};
        in_tuser  <= next_beat.pad;
        in_tvalid <= 1'b1;
        tx_gap    <= tx_idle ? $urandom_range(0, 4) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver stall, counted in cycles since reset
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_cnt <= 0;
      hold_left <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == HOLD_AT_A || cycle_cnt == HOLD_AT_B) hold_left <= LONG_HOLD;
      else if (hold_left > 0) hold_left <= hold_left - 1;
    end
  end

  // result side: check each beat, then hold off for a random number of cycles when rx_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else if (out_tvalid && out_tready) begin
      if (dilated_px_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want_px = dilated_px_q.pop_front();
        if (out_tdata !== {7'b0, want_px.pix})
          report_mismatch($sformatf("result %0d: tdata %h, expected pixel %b",
                                    results_seen, out_tdata, want_px.pix));
        if (out_tlast !== want_px.fend)
          report_mismatch($sformatf("result %0d: tlast %b, expected %b",
                                    results_seen, out_tlast, want_px.fend));
      end
      results_seen++;
      rx_draw = rx_idle ? $urandom_range(0, 4) : 0;
      rx_wait    <= rx_draw;
      out_tready <= (rx_draw == 0) && (hold_left == 0);
    end else if (rx_wait > 0) begin
      rx_wait    <= rx_wait - 1;
      out_tready <= (rx_wait == 1) && (hold_left == 0);
    end else begin
      out_tready <= (hold_left == 0);
    end
  end

  task automatic cfg_access(input logic wr, input logic [bcd_pkg::DATA_W-1:0] wdata,
                            output logic [bcd_pkg::DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= bcd_pkg::REG_IMAGE_SIDE;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_side(input logic [bcd_pkg::DATA_W-1:0] val);
    logic [bcd_pkg::DATA_W-1:0] rd;
    cfg_access(1'b1, val, rd);
    side_reg = val[bcd_pkg::CFG_W-1:0];
    restart_frame();
    cfg_access(1'b0, '0, rd);
    if (rd !== bcd_pkg::DATA_W'(val[bcd_pkg::CFG_W-1:0]))
      report_mismatch($sformatf("image_side reads %h, expected %h",
                                rd, val[bcd_pkg::CFG_W-1:0]));
  endtask

  task automatic wait_idle();
    while (pixel_fifo.size() != 0 || in_tvalid || dilated_px_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic push_beat(input int pix, input int pad);
    pixel_beat_t b;
    b.pix = pix[0];
    b.pad = pad[0];
    pixel_fifo.push_back(b);
    phase_items++;
  endtask

  task automatic push_frame(input int n);
    int density;
    int style;
    int pads;
    case ($urandom_range(0, 3))
      0:       density = 5;
      1:       density = 50;
      2:       density = 95;
      default: density = $urandom_range(0, 100);
    endcase
    // mostly clean frames; stray pads, short drain and noise otherwise
    style = $urandom_range(0, 19);
    if (style == 19) begin
      repeat ($urandom_range(1, 2 * n))
        push_beat(int'($urandom_range(0, 1)), int'($urandom_range(0, 1)));
    end else begin
      for (int i = 0; i < n * n; i++)
        push_beat(int'($urandom_range(0, 99) < density),
                  int'(style == 17 && $urandom_range(0, 9) == 0));
      pads = (style == 18) ? $urandom_range(0, n) : n + 1;
      repeat (pads) push_beat(int'($urandom_range(0, 1)), 1);
    end
  endtask

  task automatic run_phase(input logic [bcd_pkg::DATA_W-1:0] side_val, input int budget);
    int n;
    set_side(side_val);
    n = side_eff();
    tx_idle = 1'($urandom_range(0, 1));
    rx_idle = 1'($urandom_range(0, 1));
    phase_items = 0;
    while (phase_items < budget) push_frame(n);
    wait_idle();
  endtask

  initial begin
    logic [bcd_pkg::DATA_W-1:0] rd;
    logic [bcd_pkg::DATA_W-1:0] small_sides [10];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    side_reg    = bcd_pkg::SIDE_RESET;
    restart_frame();
    for (int i = 0; i < bcd_pkg::MAX_SIDE; i++) begin
      line_two_up[i] = 1'b0;
      line_one_up[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_access(1'b0, '0, rd);
    if (rd !== bcd_pkg::DATA_W'(bcd_pkg::SIDE_RESET))
      report_mismatch($sformatf("image_side after reset reads %h", rd));

    // directed: side below range acts as 3
    set_side(32'h0);
    // bottom neighbour set, left neighbour set but flagged as pad
    push_beat(0, 0); push_beat(0, 0); push_beat(0, 0);
    push_beat(1, 1); push_beat(0, 0); push_beat(0, 0);
    push_beat(0, 0); push_beat(1, 0); push_beat(0, 0);
    repeat (4) push_beat(1, 1);
    // diagonals only: cross must stay clear
    push_beat(1, 0); push_beat(0, 0); push_beat(1, 0);
    push_beat(0, 0); push_beat(0, 0); push_beat(0, 0);
    push_beat(1, 0); push_beat(0, 0); push_beat(1, 0);
    repeat (4) push_beat(0, 1);
    wait_idle();

    small_sides = '{32'h3, 32'h804, 32'h5, 32'hFFFF_F806, 32'h7, 32'h1, 32'h8, 32'hC,
                    $urandom_range(3, 10), $urandom_range(3, 10)};
    foreach (small_sides[i]) run_phase(small_sides[i], 40);

    // above range acts as the largest side: no result during the line fill
    set_side(32'h7FF);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    repeat (64) push_beat(int'($urandom_range(0, 1)), int'($urandom_range(0, 19) == 0));
    wait_idle();

    run_phase(32'h3, 40);

    if (mismatches == 0 && dilated_px_q.size() == 0) begin
      $display("binary_cross_dilation test passed");
    end else begin
      $display("binary_cross_dilation test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("binary_cross_dilation test failed");
    $finish;
  end

endmodule
